// ===== hw/rtl/adsr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope package
// Shared widths, register map, reset values and pipeline side-band types.
// ----------------------------------------------------------------------------
package adsr_pkg;

    localparam int TIME_BITS_DEF  = 32;
    localparam int LEVEL_BITS_DEF = 16;
    localparam int DUR_W          = 24;
    localparam int TICK_W         = 32;
    localparam int OUT_W          = 16;
    localparam int APB_AW         = 5;
    localparam int APB_DW         = 32;

    typedef enum logic [2:0] {
        REG_ATTACK  = 3'd0,
        REG_DECAY   = 3'd1,
        REG_RELEASE = 3'd2,
        REG_PEAK    = 3'd3,
        REG_HOLD    = 3'd4
    } reg_idx_t;

    localparam logic [DUR_W-1:0] ATTACK_RST  = 24'd441;
    localparam logic [DUR_W-1:0] DECAY_RST   = 24'd441000;
    localparam logic [DUR_W-1:0] RELEASE_RST = 24'd44100;
    localparam logic [OUT_W-1:0] PEAK_RST    = 16'd65535;
    localparam logic [OUT_W-1:0] HOLD_RST    = 16'd13107;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_SUSTAIN = 2'd2
    } phase_t;

    // Durations as the datapath sees them: a zero register acts as one tick.
    typedef struct packed {
        logic [DUR_W-1:0] att;
        logic [DUR_W-1:0] dec;
        logic [DUR_W-1:0] rls;
    } dur_t;

    typedef struct packed {
        logic             held;
        phase_t           phase;
        logic             rising;
        logic             rls_done;
        logic [DUR_W-1:0] rls_span;
    } side1_t;

    typedef struct packed {
        logic held;
        logic rls_done;
    } rel_ctl_t;

    function automatic logic [DUR_W-1:0] nonzero(input logic [DUR_W-1:0] v);
        nonzero = (v == '0) ? DUR_W'(1) : v;
    endfunction

endpackage

// ===== hw/rtl/adsr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR pipelined divider
// Restoring division, one quotient bit per stage, with side-band data.
// ----------------------------------------------------------------------------
module adsr_div #(
    parameter int DW = 24,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [DW+QW-1:0]  num,
    input  logic [DW-1:0]     den,
    input  logic [SW-1:0]     side,
    output logic              out_valid,
    output logic [QW-1:0]     quo,
    output logic [SW-1:0]     out_side
);

    // The quotient is known to fit QW bits, so the upper part of the
    // numerator is already below the divisor.
    logic              valid_reg [0:QW];
    logic [DW-1:0]     rem_reg   [0:QW];
    logic [QW-1:0]     low_reg   [0:QW];
    logic [QW-1:0]     quo_reg   [0:QW];
    logic [DW-1:0]     den_reg   [0:QW];
    logic [SW-1:0]     side_reg  [0:QW];

    logic [DW:0]       trial     [0:QW-1];
    logic [DW:0]       diff      [0:QW-1];
    logic              ge        [0:QW-1];
    logic [DW-1:0]     rem_next  [0:QW-1];

    always_comb
    begin
        for (int k = 0; k < QW; k++)
        begin
            trial[k]    = {rem_reg[k], low_reg[k][QW-1]};
            diff[k]     = trial[k] - {1'b0, den_reg[k]};
            ge[k]       = (trial[k] >= {1'b0, den_reg[k]});
            rem_next[k] = ge[k] ? diff[k][DW-1:0] : trial[k][DW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 0; k < QW; k++)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0]  <= num[DW+QW-1:QW];
        low_reg[0]  <= num[QW-1:0];
        quo_reg[0]  <= '0;
        den_reg[0]  <= den;
        side_reg[0] <= side;
        for (int k = 0; k < QW; k++)
        begin
            rem_reg[k+1]  <= rem_next[k];
            low_reg[k+1]  <= {low_reg[k][QW-2:0], 1'b0};
            quo_reg[k+1]  <= {quo_reg[k][QW-2:0], ge[k]};
            den_reg[k+1]  <= den_reg[k];
            side_reg[k+1] <= side_reg[k];
        end
    end

    assign out_valid = valid_reg[QW];
    assign quo       = quo_reg[QW];
    assign out_side  = side_reg[QW];

    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[QW] |-> (rem_reg[QW] < den_reg[QW]))
        else $error("divider remainder not below divisor");

endmodule

// ===== hw/rtl/adsr_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR front end
// Elapsed times, envelope phase selection and the first product.
// ----------------------------------------------------------------------------
module adsr_front #(
    parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [TIME_BITS-1:0]                 now_tick,
    input  logic [TIME_BITS-1:0]                 on_tick,
    input  logic [TIME_BITS-1:0]                 off_tick,
    input  adsr_pkg::dur_t                       dur,
    input  logic [LEVEL_BITS-1:0]                peak,
    input  logic [LEVEL_BITS-1:0]                hold,
    output logic                                 out_valid,
    output logic [adsr_pkg::DUR_W+LEVEL_BITS-1:0] num,
    output logic [adsr_pkg::DUR_W-1:0]           den,
    output adsr_pkg::side1_t                     side
);

    localparam int DW = adsr_pkg::DUR_W;
    localparam int NW = DW + LEVEL_BITS;
    localparam int CW = (TIME_BITS > DW + 1) ? TIME_BITS : DW + 1;

    // Stage 0: input word.
    logic                  v0_reg;
    logic [TIME_BITS-1:0]  now0_reg;
    logic [TIME_BITS-1:0]  on0_reg;
    logic [TIME_BITS-1:0]  off0_reg;

    // Stage 1: elapsed times.
    logic                  v1_reg;
    logic                  held1_reg;
    logic [TIME_BITS-1:0]  life1_reg;
    logic [TIME_BITS-1:0]  drel1_reg;
    logic                  held1_next;
    logic [TIME_BITS-1:0]  life1_next;

    // Stage 2: phase and multiplier operands.
    logic                  v2_reg;
    logic [DW-1:0]         m1_reg;
    logic [LEVEL_BITS-1:0] m2_reg;
    logic [DW-1:0]         den2_reg;
    adsr_pkg::side1_t      side2_reg;
    logic [DW-1:0]         m1_next;
    logic [LEVEL_BITS-1:0] m2_next;
    logic [DW-1:0]         den2_next;
    adsr_pkg::side1_t      side2_next;
    logic [CW-1:0]         life_w;
    logic [CW-1:0]         att_w;
    logic [CW-1:0]         att_dec_w;
    logic [CW-1:0]         span_w;
    logic                  rising;
    logic [LEVEL_BITS-1:0] delta;

    // Stage 3: product.
    logic                  v3_reg;
    logic [NW-1:0]         num3_reg;
    logic [DW-1:0]         den3_reg;
    adsr_pkg::side1_t      side3_reg;
    logic [NW-1:0]         prod;

    always_comb
    begin
        held1_next = (on0_reg > off0_reg);
        life1_next = held1_next ? (now0_reg - on0_reg) : (off0_reg - on0_reg);
    end

    always_comb
    begin
        life_w    = CW'(life1_reg);
        att_w     = CW'(dur.att);
        att_dec_w = CW'(dur.att) + CW'(dur.dec);
        span_w    = life_w - att_w;
        rising    = (hold >= peak);
        delta     = rising ? (hold - peak) : (peak - hold);

        side2_next.held     = held1_reg;
        side2_next.rising   = rising;
        side2_next.rls_done = (CW'(drel1_reg) >= CW'(dur.rls));
        side2_next.rls_span = DW'(drel1_reg);

        if (life_w <= att_w)
        begin
            side2_next.phase = adsr_pkg::PH_ATTACK;
            m1_next          = DW'(life_w);
            m2_next          = peak;
            den2_next        = dur.att;
        end
        else if (life_w <= att_dec_w)
        begin
            side2_next.phase = adsr_pkg::PH_DECAY;
            m1_next          = DW'(span_w);
            m2_next          = delta;
            den2_next        = dur.dec;
        end
        else
        begin
            side2_next.phase = adsr_pkg::PH_SUSTAIN;
            m1_next          = '0;
            m2_next          = '0;
            den2_next        = dur.dec;
        end
    end

    assign prod = m1_reg * m2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        now0_reg  <= now_tick;
        on0_reg   <= on_tick;
        off0_reg  <= off_tick;
        held1_reg <= held1_next;
        life1_reg <= life1_next;
        drel1_reg <= now0_reg - off0_reg;
        m1_reg    <= m1_next;
        m2_reg    <= m2_next;
        den2_reg  <= den2_next;
        side2_reg <= side2_next;
        num3_reg  <= prod;
        den3_reg  <= den2_reg;
        side3_reg <= side2_reg;
    end

    assign out_valid = v3_reg;
    assign num       = num3_reg;
    assign den       = den3_reg;
    assign side      = side3_reg;

endmodule

// ===== hw/rtl/adsr_rel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR release setup
// Forms the held level and the release product for the second division.
// ----------------------------------------------------------------------------
module adsr_rel #(
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    input  logic [LEVEL_BITS-1:0]                 quo,
    input  adsr_pkg::side1_t                      side,
    input  logic [LEVEL_BITS-1:0]                 peak,
    input  logic [LEVEL_BITS-1:0]                 hold,
    output logic                                  out_valid,
    output logic [adsr_pkg::DUR_W+LEVEL_BITS-1:0] num,
    output logic [LEVEL_BITS-1:0]                 lvl,
    output adsr_pkg::rel_ctl_t                    ctl
);

    localparam int DW = adsr_pkg::DUR_W;
    localparam int NW = DW + LEVEL_BITS;

    logic                  v0_reg;
    logic [LEVEL_BITS-1:0] lvl0_reg;
    logic [DW-1:0]         span0_reg;
    adsr_pkg::rel_ctl_t    ctl0_reg;
    logic [LEVEL_BITS-1:0] lvl0_next;

    logic                  v1_reg;
    logic [NW-1:0]         num1_reg;
    logic [LEVEL_BITS-1:0] lvl1_reg;
    adsr_pkg::rel_ctl_t    ctl1_reg;
    logic [NW-1:0]         prod;

    always_comb
    begin
        unique case (side.phase)
            adsr_pkg::PH_ATTACK:  lvl0_next = quo;
            adsr_pkg::PH_DECAY:   lvl0_next = side.rising ? (peak + quo) : (peak - quo);
            adsr_pkg::PH_SUSTAIN: lvl0_next = hold;
            default:              lvl0_next = hold;
        endcase
    end

    assign prod = span0_reg * lvl0_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
        end
    end

    // The span only matters inside the release; elsewhere it is zeroed so the
    // quotient of the second division always fits the level width.
    always_ff @(posedge clk)
    begin
        lvl0_reg          <= lvl0_next;
        span0_reg         <= (side.held || side.rls_done) ? '0 : side.rls_span;
        ctl0_reg.held     <= side.held;
        ctl0_reg.rls_done <= side.rls_done;
        num1_reg          <= prod;
        lvl1_reg          <= lvl0_reg;
        ctl1_reg          <= ctl0_reg;
    end

    assign out_valid = v1_reg;
    assign num       = num1_reg;
    assign lvl       = lvl1_reg;
    assign ctl       = ctl1_reg;

endmodule

// ===== hw/rtl/adsr_envelope_level.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope level generator
// Path: front end, first divider, release setup, second divider and output
// register; the two bit-per-stage dividers work in series.
// Throughput: one word per cycle; busy is never raised and done cannot stall.
// Reset: the pipeline empties at once and the registers take their defaults.
// ----------------------------------------------------------------------------
module adsr_envelope_level #(
    parameter int TIME_BITS  = adsr_pkg::TIME_BITS_DEF,
    parameter int LEVEL_BITS = adsr_pkg::LEVEL_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [adsr_pkg::APB_AW-1:0]   paddr,
    input  logic [adsr_pkg::APB_DW-1:0]   pwdata,
    output logic [adsr_pkg::APB_DW-1:0]   prdata,
    output logic                          pready,
    input  logic                          start,
    output logic                          busy,
    input  logic [adsr_pkg::TICK_W-1:0]   now_tick,
    input  logic [adsr_pkg::TICK_W-1:0]   on_tick,
    input  logic [adsr_pkg::TICK_W-1:0]   off_tick,
    output logic                          done,
    output logic [adsr_pkg::OUT_W-1:0]    level
);

    localparam int DW  = adsr_pkg::DUR_W;
    localparam int NW  = DW + LEVEL_BITS;
    localparam int SW2 = $bits(adsr_pkg::rel_ctl_t) + LEVEL_BITS;
    localparam int LAT = 2 * LEVEL_BITS + 9;
    localparam logic [LEVEL_BITS-1:0] EPS = LEVEL_BITS'(((1 << LEVEL_BITS) - 1) / 10000);

    logic [DW-1:0]         attack_reg;
    logic [DW-1:0]         decay_reg;
    logic [DW-1:0]         release_reg;
    logic [LEVEL_BITS-1:0] peak_reg;
    logic [LEVEL_BITS-1:0] hold_reg;
    adsr_pkg::dur_t        dur;
    logic                  accept;

    logic                  f_valid;
    logic [NW-1:0]         f_num;
    logic [DW-1:0]         f_den;
    adsr_pkg::side1_t      f_side;

    logic                  d1_valid;
    logic [LEVEL_BITS-1:0] d1_quo;
    logic [$bits(adsr_pkg::side1_t)-1:0] d1_side;

    logic                  r_valid;
    logic [NW-1:0]         r_num;
    logic [LEVEL_BITS-1:0] r_lvl;
    adsr_pkg::rel_ctl_t    r_ctl;

    logic                  d2_valid;
    logic [LEVEL_BITS-1:0] d2_quo;
    logic [SW2-1:0]        d2_side;
    adsr_pkg::rel_ctl_t    d2_ctl;
    logic [LEVEL_BITS-1:0] d2_lvl;

    logic                  out_valid_reg;
    logic [LEVEL_BITS-1:0] lvl_reg;
    logic [LEVEL_BITS-1:0] lvl_raw;
    logic [LEVEL_BITS-1:0] lvl_next;

    assign pready = 1'b1;
    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= adsr_pkg::ATTACK_RST;
            decay_reg   <= adsr_pkg::DECAY_RST;
            release_reg <= adsr_pkg::RELEASE_RST;
            peak_reg    <= LEVEL_BITS'(adsr_pkg::PEAK_RST);
            hold_reg    <= LEVEL_BITS'(adsr_pkg::HOLD_RST);
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[4:2])
                adsr_pkg::REG_ATTACK:  attack_reg  <= DW'(pwdata);
                adsr_pkg::REG_DECAY:   decay_reg   <= DW'(pwdata);
                adsr_pkg::REG_RELEASE: release_reg <= DW'(pwdata);
                adsr_pkg::REG_PEAK:    peak_reg    <= LEVEL_BITS'(pwdata);
                adsr_pkg::REG_HOLD:    hold_reg    <= LEVEL_BITS'(pwdata);
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            adsr_pkg::REG_ATTACK:  prdata = adsr_pkg::APB_DW'(attack_reg);
            adsr_pkg::REG_DECAY:   prdata = adsr_pkg::APB_DW'(decay_reg);
            adsr_pkg::REG_RELEASE: prdata = adsr_pkg::APB_DW'(release_reg);
            adsr_pkg::REG_PEAK:    prdata = adsr_pkg::APB_DW'(peak_reg);
            adsr_pkg::REG_HOLD:    prdata = adsr_pkg::APB_DW'(hold_reg);
            default:               prdata = '0;
        endcase
    end

    assign dur.att = adsr_pkg::nonzero(attack_reg);
    assign dur.dec = adsr_pkg::nonzero(decay_reg);
    assign dur.rls = adsr_pkg::nonzero(release_reg);

    adsr_front #(
        .TIME_BITS  (TIME_BITS),
        .LEVEL_BITS (LEVEL_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .now_tick  (TIME_BITS'(now_tick)),
        .on_tick   (TIME_BITS'(on_tick)),
        .off_tick  (TIME_BITS'(off_tick)),
        .dur       (dur),
        .peak      (peak_reg),
        .hold      (hold_reg),
        .out_valid (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side      (f_side)
    );

    adsr_div #(
        .DW (DW),
        .QW (LEVEL_BITS),
        .SW ($bits(adsr_pkg::side1_t))
    ) u_div_held (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .num       (f_num),
        .den       (f_den),
        .side      (f_side),
        .out_valid (d1_valid),
        .quo       (d1_quo),
        .out_side  (d1_side)
    );

    adsr_rel #(
        .LEVEL_BITS (LEVEL_BITS)
    ) u_rel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d1_valid),
        .quo       (d1_quo),
        .side      (adsr_pkg::side1_t'(d1_side)),
        .peak      (peak_reg),
        .hold      (hold_reg),
        .out_valid (r_valid),
        .num       (r_num),
        .lvl       (r_lvl),
        .ctl       (r_ctl)
    );

    adsr_div #(
        .DW (DW),
        .QW (LEVEL_BITS),
        .SW (SW2)
    ) u_div_rel (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (r_valid),
        .num       (r_num),
        .den       (dur.rls),
        .side      ({r_ctl, r_lvl}),
        .out_valid (d2_valid),
        .quo       (d2_quo),
        .out_side  (d2_side)
    );

    assign d2_ctl = adsr_pkg::rel_ctl_t'(d2_side[SW2-1:LEVEL_BITS]);
    assign d2_lvl = d2_side[LEVEL_BITS-1:0];

    always_comb
    begin
        if (d2_ctl.held)
        begin
            lvl_raw = d2_lvl;
        end
        else if (d2_ctl.rls_done)
        begin
            lvl_raw = '0;
        end
        else
        begin
            lvl_raw = d2_lvl - d2_quo;
        end
        lvl_next = (lvl_raw <= EPS) ? '0 : lvl_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg <= lvl_next;
    end

    assign done  = out_valid_reg;
    assign level = adsr_pkg::OUT_W'(lvl_reg);

    a_word_out: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LAT done)
        else $error("accepted word did not come out on time");

    a_no_extra_word: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LAT))
        else $error("done without a matching accepted word");

    a_floor: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((lvl_reg == '0) || (lvl_reg > EPS)))
        else $error("level below the floor was not forced to zero");

endmodule
